// ===== hdl/tick_driven_mlfq_rr_fifo_scheduler_macros.svh =====
// Assertion macros used by the scheduler's top-level RTL file.
`ifndef TICK_DRIVEN_MLFQ_RR_FIFO_SCHEDULER_MACROS_SVH
`define TICK_DRIVEN_MLFQ_RR_FIFO_SCHEDULER_MACROS_SVH

// Antecedent holds at an edge, so the consequent must hold at the same edge.
`define TDMS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds at an edge, so the consequent must hold at the next edge.
`define TDMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tdms_pkg.sv =====
// Shared types and constants of the tick-driven scheduler.
package tdms_pkg;

    localparam int MODE_W   = 2;
    localparam int SLICE_W  = 16;
    localparam int TICKMS_W = 10;
    localparam int ID_W     = 4;
    localparam int BURST_W  = 16;
    localparam int TIME_W   = 32;
    localparam int EV_W     = 2;
    localparam int PRIO_W   = 2;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [MODE_W-1:0] MODE_RR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MLFQ = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIFO = 2'd2;

    localparam logic [EV_W-1:0] EV_DONE     = 2'd0;
    localparam logic [EV_W-1:0] EV_PREEMPT  = 2'd1;
    localparam logic [EV_W-1:0] EV_DISPATCH = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_SLICE = 2'd1;
    localparam logic [1:0] REG_TICK  = 2'd2;

    localparam logic [MODE_W-1:0]   MODE_RESET  = MODE_RR;
    localparam logic [SLICE_W-1:0]  SLICE_RESET = 16'd50;
    localparam logic [TICKMS_W-1:0] TICK_RESET  = 10'd10;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [SLICE_W-1:0]  time_slice_ms;
        logic [TICKMS_W-1:0] tick_ms;
    } t_cfg;

    typedef struct packed {
        logic [EV_W-1:0]   event_code;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] time_ms;
        logic              last;
    } t_result;

endpackage

// ===== hdl/tdms_cfg.sv =====
// APB register file holding the scheduling policy, slice length and tick length.
module tdms_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tdms_pkg::APB_AW-1:0]  paddr,
    input  logic [tdms_pkg::APB_DW-1:0]  pwdata,
    output logic [tdms_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output tdms_pkg::t_cfg               o_cfg
);

    tdms_pkg::t_cfg r_cfg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= tdms_pkg::MODE_RESET;
            r_cfg.time_slice_ms <= tdms_pkg::SLICE_RESET;
            r_cfg.tick_ms       <= tdms_pkg::TICK_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                tdms_pkg::REG_MODE: begin
                    r_cfg.mode <= pwdata[tdms_pkg::MODE_W-1:0];
                end
                tdms_pkg::REG_SLICE: begin
                    r_cfg.time_slice_ms <= pwdata[tdms_pkg::SLICE_W-1:0];
                end
                tdms_pkg::REG_TICK: begin
                    r_cfg.tick_ms <= pwdata[tdms_pkg::TICKMS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tdms_pkg::REG_MODE: begin
                prdata = tdms_pkg::APB_DW'(r_cfg.mode);
            end
            tdms_pkg::REG_SLICE: begin
                prdata = tdms_pkg::APB_DW'(r_cfg.time_slice_ms);
            end
            tdms_pkg::REG_TICK: begin
                prdata = tdms_pkg::APB_DW'(r_cfg.tick_ms);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

// ===== hdl/tdms_out.sv =====
// Output register that holds one result transaction until the receiver takes it.
module tdms_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tdms_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_valid,
    output tdms_pkg::t_result o_res,
    output logic              o_free
);

    logic              r_valid;
    tdms_pkg::t_result r_res;

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_free  = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== hdl/tdms_core.sv =====
// Scheduler sequencer with the task and link memories and the ready queue pointers.
module tdms_core #(
    parameter int TASK_COUNT  = 16,
    parameter int QUEUE_COUNT = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tdms_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [tdms_pkg::ID_W-1:0]     i_task_id,
    input  logic [tdms_pkg::BURST_W-1:0]  i_burst_ms,
    input  logic [tdms_pkg::TIME_W-1:0]   i_time_ms,
    input  logic                          i_out_free,
    output logic                          o_out_load,
    output tdms_pkg::t_result             o_out_res
);

    localparam int TW = $clog2(TASK_COUNT);
    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int IW = (TW > tdms_pkg::ID_W) ? TW : tdms_pkg::ID_W;
    localparam int PW = tdms_pkg::PRIO_W;
    localparam int BW = tdms_pkg::BURST_W;
    localparam logic [QW-1:0] QMAX = QW'(QUEUE_COUNT - 1);

    typedef struct packed {
        logic [QW-1:0] prio;
        logic [BW-1:0] burst;
        logic [BW-1:0] elapsed;
    } t_task;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RDY  = 6'b000010,
        S_TICK = 6'b000100,
        S_DSP  = 6'b001000,
        S_POP  = 6'b010000,
        S_WAIT = 6'b100000
    } t_state;

    // Per-task memories, one read port each with a registered output.
    t_task         task_mem [TASK_COUNT];
    logic [TW-1:0] link_mem [TASK_COUNT];

    t_state                      r_state, n_state;
    logic [TASK_COUNT-1:0]       r_tvalid;
    t_task                       r_trd;
    logic                        r_trd_v;
    logic [TW-1:0]               r_lrd;
    logic [QW-1:0]               r_dq;
    logic [TW-1:0]               r_head [QUEUE_COUNT];
    logic [TW-1:0]               r_tail [QUEUE_COUNT];
    logic [QUEUE_COUNT-1:0]      r_nonempty;
    logic                        r_run_valid, n_run_valid;
    logic [TW-1:0]               r_run_task, n_run_task;
    logic [BW-1:0]               r_slice, n_slice;
    tdms_pkg::t_result           r_hold, n_hold;
    logic                        r_hold_v, n_hold_v;
    logic [TW-1:0]               r_id;
    logic [BW-1:0]               r_burst;
    logic [tdms_pkg::TIME_W-1:0] r_time;

    logic          in_accept;
    logic          in_ok;
    logic [IW-1:0] in_id_w;
    logic [TW-1:0] in_idx;
    logic [TW-1:0] tm_raddr;
    logic          tm_we;
    logic [TW-1:0] tm_waddr;
    t_task         tm_wdata;
    logic          lm_we;
    logic          push_en;
    logic [QW-1:0] push_q;
    logic [TW-1:0] push_t;
    logic          pop_en;
    logic [QW-1:0] sel_q;
    logic          any_ne;
    logic          feedback;
    logic          preemptive;
    logic [QW-1:0] prio_rd;
    logic [QW-1:0] prio_dn;
    logic [QW-1:0] q_up;
    logic [QW-1:0] q_rdy;
    logic [BW:0]   el_sum;
    logic [BW:0]   su_sum;
    logic [BW-1:0] el;
    logic [BW-1:0] su;
    logic          burst_done;
    logic          slice_up;
    tdms_pkg::t_result pop_res;

    function automatic logic [QW-1:0] clamp_q(input logic [QW:0] p);
        clamp_q = (p >= (QW+1)'(QUEUE_COUNT)) ? QMAX : p[QW-1:0];
    endfunction

    function automatic tdms_pkg::t_result mk_res(
        input logic [tdms_pkg::EV_W-1:0]   ev,
        input logic [TW-1:0]               t,
        input logic [QW-1:0]               q,
        input logic [tdms_pkg::TIME_W-1:0] tm,
        input logic                        last
    );
        tdms_pkg::t_result res;
        logic [IW-1:0]     tw;
        tw             = IW'(t);
        res.event_code = ev;
        res.task_id    = tw[tdms_pkg::ID_W-1:0];
        res.prio       = PW'(q);
        res.time_ms    = tm;
        res.last       = last;
        mk_res         = res;
    endfunction

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_id_w    = IW'(i_task_id);
    assign in_idx     = in_id_w[TW-1:0];
    assign in_ok      = (32'(i_task_id) < TASK_COUNT);
    assign tm_raddr   = i_kind ? in_idx : r_run_task;

    assign feedback   = (i_cfg.mode == tdms_pkg::MODE_MLFQ);
    assign preemptive = (i_cfg.mode == tdms_pkg::MODE_RR) || feedback;

    // A task that was never written still has its reset priority of zero.
    assign prio_rd = r_trd_v ? r_trd.prio : '0;
    assign prio_dn = (feedback && (prio_rd != '0)) ? prio_rd - QW'(1) : prio_rd;
    assign q_up    = feedback ? clamp_q({1'b0, prio_rd} + (QW+1)'(1)) : '0;
    assign q_rdy   = feedback ? clamp_q({1'b0, prio_rd}) : '0;

    assign el_sum     = {1'b0, r_trd.elapsed} + (BW+1)'(i_cfg.tick_ms);
    assign su_sum     = {1'b0, r_slice} + (BW+1)'(i_cfg.tick_ms);
    assign el         = el_sum[BW] ? '1 : el_sum[BW-1:0];
    assign su         = su_sum[BW] ? '1 : su_sum[BW-1:0];
    assign burst_done = (el >= r_trd.burst);
    assign slice_up   = preemptive && (su >= i_cfg.time_slice_ms);

    assign any_ne  = |r_nonempty;
    assign lm_we   = push_en && r_nonempty[push_q];
    assign pop_res = mk_res(tdms_pkg::EV_DISPATCH, r_head[r_dq], r_dq, r_time, 1'b1);

    always_comb begin
        sel_q = '0;
        for (int q = QUEUE_COUNT - 1; q >= 0; q--) begin
            if (r_nonempty[q]) begin
                sel_q = QW'(q);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_run_valid = r_run_valid;
        n_run_task  = r_run_task;
        n_slice     = r_slice;
        n_hold      = r_hold;
        n_hold_v    = r_hold_v;
        tm_we       = 1'b0;
        tm_waddr    = r_id;
        tm_wdata    = r_trd;
        push_en     = 1'b0;
        push_q      = '0;
        push_t      = r_id;
        pop_en      = 1'b0;
        o_out_load  = 1'b0;
        o_out_res   = r_hold;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_hold_v = 1'b0;
                    if (i_kind) begin
                        n_state = in_ok ? S_RDY : S_IDLE;
                    end else begin
                        n_state = r_run_valid ? S_TICK : S_DSP;
                    end
                end
            end
            S_RDY: begin
                tm_we            = 1'b1;
                tm_waddr         = r_id;
                tm_wdata.prio    = feedback ? q_rdy : prio_rd;
                tm_wdata.burst   = r_burst;
                tm_wdata.elapsed = '0;
                push_en          = 1'b1;
                push_q           = q_rdy;
                push_t           = r_id;
                n_state          = S_IDLE;
            end
            S_TICK: begin
                tm_we            = 1'b1;
                tm_waddr         = r_run_task;
                tm_wdata.prio    = prio_rd;
                tm_wdata.burst   = r_trd.burst;
                tm_wdata.elapsed = el;
                n_slice          = su;
                if (burst_done) begin
                    tm_wdata.prio = prio_dn;
                    n_hold   = mk_res(tdms_pkg::EV_DONE, r_run_task, prio_dn, r_time,
                                      !any_ne);
                    n_hold_v    = 1'b1;
                    n_run_valid = 1'b0;
                end else if (slice_up) begin
                    tm_wdata.prio = feedback ? q_up : prio_rd;
                    n_slice       = '0;
                    push_en       = 1'b1;
                    push_q        = q_up;
                    push_t        = r_run_task;
                    // The preempted task is requeued, so a dispatch always follows.
                    n_hold   = mk_res(tdms_pkg::EV_PREEMPT, r_run_task, q_up, r_time, 1'b0);
                    n_hold_v    = 1'b1;
                    n_run_valid = 1'b0;
                end
                n_state = S_DSP;
            end
            S_DSP: begin
                // The link memory reads the selected head here, ready for the pop.
                if (!r_hold_v || i_out_free) begin
                    if (r_hold_v) begin
                        o_out_load = 1'b1;
                        o_out_res  = r_hold;
                        n_hold_v   = 1'b0;
                    end
                    n_state = (!r_run_valid && any_ne) ? S_POP : S_IDLE;
                end
            end
            S_POP: begin
                pop_en      = 1'b1;
                n_run_task  = r_head[r_dq];
                n_run_valid = 1'b1;
                n_slice     = '0;
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    o_out_res  = pop_res;
                    n_state    = S_IDLE;
                end else begin
                    n_hold   = pop_res;
                    n_hold_v = 1'b1;
                    n_state  = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    o_out_res  = r_hold;
                    n_hold_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_valid <= 1'b0;
            r_run_task  <= '0;
            r_slice     <= '0;
            r_hold_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run_valid <= n_run_valid;
            r_run_task  <= n_run_task;
            r_slice     <= n_slice;
            r_hold_v    <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (in_accept) begin
            r_id    <= in_idx;
            r_burst <= i_burst_ms;
            r_time  <= i_time_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
            for (int q = 0; q < QUEUE_COUNT; q++) begin
                r_head[q] <= '0;
                r_tail[q] <= '0;
            end
        end else begin
            if (push_en) begin
                if (!r_nonempty[push_q]) begin
                    r_head[push_q]     <= push_t;
                    r_nonempty[push_q] <= 1'b1;
                end
                r_tail[push_q] <= push_t;
            end
            if (pop_en) begin
                if (r_head[r_dq] == r_tail[r_dq]) begin
                    r_nonempty[r_dq] <= 1'b0;
                end else begin
                    r_head[r_dq] <= r_lrd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= '0;
        end else if (tm_we) begin
            r_tvalid[tm_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tm_we) begin
            task_mem[tm_waddr] <= tm_wdata;
        end
        r_trd   <= task_mem[tm_raddr];
        r_trd_v <= r_tvalid[tm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (lm_we) begin
            link_mem[r_tail[push_q]] <= push_t;
        end
        r_lrd <= link_mem[r_head[sel_q]];
        r_dq  <= sel_q;
    end

endmodule

// ===== hdl/tick_driven_mlfq_rr_fifo_scheduler.sv =====
// Tick-driven scheduler over linked ready queues.
//
// Input channel (i_in_valid / o_in_stall): a transaction is a tick (i_kind 0)
// or a task made ready (i_kind 1) with its burst length. Output channel
// (o_out_valid / i_out_stall): done, preempted and dispatched events, with
// o_last marking the final event caused by one input transaction.
// The APB port sets the policy, slice length and tick length; write it only
// while the block is idle. pready is always high.
// A ready transaction writes the task and pushes it onto its queue. A tick
// reads the running task, does its read-modify-write (skipped when no task
// runs), selects a queue while its head link is read, and pops a head when no
// task runs. A tick's done or preempted event reaches the output register
// before its dispatch. The task and link memories have one read port each,
// which sets these steps.
// Reset empties all queues, clears the running task and sets all priorities
// to zero. When the receiver stalls, one event waits in the output register
// and one in the sequencer; the block stalls its input until the sequencer's event has moved on.
module tick_driven_mlfq_rr_fifo_scheduler #(
    parameter int TASK_COUNT  = 16,
    parameter int QUEUE_COUNT = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tdms_pkg::APB_AW-1:0]   paddr,
    input  logic [tdms_pkg::APB_DW-1:0]   pwdata,
    output logic [tdms_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [tdms_pkg::ID_W-1:0]     i_task_id,
    input  logic [tdms_pkg::BURST_W-1:0]  i_burst_ms,
    input  logic [tdms_pkg::TIME_W-1:0]   i_time_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tdms_pkg::EV_W-1:0]     o_event_res,
    output logic [tdms_pkg::ID_W-1:0]     o_task_id_res,
    output logic [tdms_pkg::PRIO_W-1:0]   o_priority_res,
    output logic [tdms_pkg::TIME_W-1:0]   o_time_ms_res,
    output logic                          o_last
);

`include "tick_driven_mlfq_rr_fifo_scheduler_macros.svh"

    tdms_pkg::t_cfg    cfg;
    tdms_pkg::t_result core_res;
    tdms_pkg::t_result out_res;
    logic              core_load;
    logic              out_free;

    tdms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tdms_core #(
        .TASK_COUNT  (TASK_COUNT),
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_task_id  (i_task_id),
        .i_burst_ms (i_burst_ms),
        .i_time_ms  (i_time_ms),
        .i_out_free (out_free),
        .o_out_load (core_load),
        .o_out_res  (core_res)
    );

    tdms_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (core_load),
        .i_res   (core_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (out_res),
        .o_free  (out_free)
    );

    assign o_event_res    = out_res.event_code;
    assign o_task_id_res  = out_res.task_id;
    assign o_priority_res = out_res.prio;
    assign o_time_ms_res  = out_res.time_ms;
    assign o_last         = out_res.last;

    `TDMS_ASSERT_IMPLIES(a_load_when_free, i_clk, i_rst_n, core_load, out_free, "event loaded over a held result")
    `TDMS_ASSERT_IMPLIES(a_dispatch_last, i_clk, i_rst_n, o_out_valid && (o_event_res == tdms_pkg::EV_DISPATCH), o_last, "dispatch event without last")
    `TDMS_ASSERT_NEXT(a_accept_no_load, i_clk, i_rst_n, i_in_valid && !o_in_stall, !core_load, "event loaded right after an input transaction")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the tick-driven scheduler with its event scoreboard.
`timescale 1ns / 100ps

import tdms_pkg::*;

localparam int SCHED_TASKS  = 16;
localparam int SCHED_QUEUES = 3;

// Tracks the scheduler's queues and running task and holds the events still due.
class sched_scoreboard;
    logic [MODE_W-1:0]   mode_reg;
    logic [SLICE_W-1:0]  slice_len;
    logic [TICKMS_W-1:0] tick_len;
    logic [PRIO_W-1:0]   prio [SCHED_TASKS];
    logic [BURST_W-1:0]  burst_len [SCHED_TASKS];
    logic [BURST_W-1:0]  elapsed [SCHED_TASKS];
    logic [ID_W-1:0]     link [SCHED_TASKS];
    logic [ID_W-1:0]     head [SCHED_QUEUES];
    logic [ID_W-1:0]     tail [SCHED_QUEUES];
    bit [SCHED_QUEUES-1:0] filled;
    bit                  running;
    logic [ID_W-1:0]     cur_task;
    logic [SLICE_W-1:0]  slice_used;
    bit [SCHED_TASKS-1:0] in_flight;
    t_result             due_events [$];
    int                  errors;

    function new();
        mode_reg = MODE_RESET;
        slice_len = SLICE_RESET;
        tick_len = TICK_RESET;
        foreach (prio[i]) begin
            prio[i] = '0;
            burst_len[i] = '0;
            elapsed[i] = '0;
            link[i] = '0;
        end
        foreach (head[q]) begin
            head[q] = '0;
            tail[q] = '0;
        end
        filled = '0;
        running = 1'b0;
        cur_task = '0;
        slice_used = '0;
        in_flight = '0;
        errors = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
        case (idx)
            REG_MODE: mode_reg = value[MODE_W-1:0];
            REG_SLICE: slice_len = value[SLICE_W-1:0];
            REG_TICK: tick_len = value[TICKMS_W-1:0];
            default: ;
        endcase
    endfunction

    function bit cpu_idle();
        return !running && filled == '0;
    endfunction

    function logic [15:0] add_sat(logic [15:0] a, logic [TICKMS_W-1:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {7'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function logic [PRIO_W-1:0] clamp_queue(int p);
        return (p >= SCHED_QUEUES) ? PRIO_W'(SCHED_QUEUES - 1) : PRIO_W'(p);
    endfunction

    function void enqueue(logic [PRIO_W-1:0] q, logic [ID_W-1:0] t);
        if (filled[q]) begin
            link[tail[q]] = t;
        end else begin
            head[q] = t;
            filled[q] = 1'b1;
        end
        tail[q] = t;
    endfunction

    function logic [ID_W-1:0] dequeue(int q);
        logic [ID_W-1:0] h;
        h = head[q];
        if (h == tail[q]) begin
            filled[q] = 1'b0;
        end else begin
            head[q] = link[h];
        end
        return h;
    endfunction

    // Advances the schedule by one accepted transaction and queues its events.
    function void apply_input(logic kind, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
                              logic [TIME_W-1:0] stamp);
        t_result ev [2];
        int n;
        logic [ID_W-1:0] t;
        logic [PRIO_W-1:0] q;
        bit feedback;
        bit preemptive;
        n = 0;
        feedback = (mode_reg == MODE_MLFQ);
        preemptive = (mode_reg == MODE_RR) || feedback;
        if (kind) begin
            q = '0;
            burst_len[id] = burst;
            elapsed[id] = '0;
            if (feedback) begin
                q = clamp_queue(int'(prio[id]));
                prio[id] = q;
            end
            enqueue(q, id);
            in_flight[id] = 1'b1;
            return;
        end
        if (running) begin
            t = cur_task;
            elapsed[t] = add_sat(elapsed[t], tick_len);
            slice_used = add_sat(slice_used, tick_len);
            if (elapsed[t] >= burst_len[t]) begin
                if (feedback && prio[t] != '0) prio[t] = prio[t] - 1'b1;
                ev[n] = '{EV_DONE, t, prio[t], stamp, 1'b0};
                n++;
                running = 1'b0;
                in_flight[t] = 1'b0;
            end else if (preemptive && slice_used >= slice_len) begin
                q = '0;
                if (feedback) begin
                    q = clamp_queue(int'(prio[t]) + 1);
                    prio[t] = q;
                end
                slice_used = '0;
                enqueue(q, t);
                ev[n] = '{EV_PREEMPT, t, q, stamp, 1'b0};
                n++;
                running = 1'b0;
            end
        end
        if (!running) begin
            for (int i = 0; i < SCHED_QUEUES; i++) begin
                if (filled[i]) begin
                    t = dequeue(i);
                    cur_task = t;
                    running = 1'b1;
                    slice_used = '0;
                    ev[n] = '{EV_DISPATCH, t, PRIO_W'(i), stamp, 1'b0};
                    n++;
                    break;
                end
            end
        end
        if (n > 0) ev[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) due_events.push_back(ev[i]);
    endfunction

    function void check_event(t_result got);
        t_result want;
        bit bad;
        if (due_events.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected event: ev=%0d task=%0d prio=%0d time=%h last=%0b",
                         got.event_code, got.task_id, got.prio, got.time_ms, got.last);
            return;
        end
        want = due_events.pop_front();
        bad = (got.event_code !== want.event_code) || (got.task_id !== want.task_id) ||
              (got.prio !== want.prio) || (got.time_ms !== want.time_ms) ||
              (got.last !== want.last);
        if (bad) begin
            errors++;
            if (errors <= 10)
                $display("event mismatch: expected ev=%0d task=%0d prio=%0d time=%h last=%0b, %s",
                         want.event_code, want.task_id, want.prio, want.time_ms, want.last,
                         $sformatf("got ev=%0d task=%0d prio=%0d time=%h last=%0b",
                                   got.event_code, got.task_id, got.prio, got.time_ms,
                                   got.last));
        end
    endfunction
endclass

module tb_top;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int PHASE_ITEMS     = 60;
    localparam int SETTLE_CYCLES   = 10;
    localparam int DRAIN_TICKS     = 400;
    localparam int WATCHDOG_CYCLES = 2000;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;
    logic in_valid;
    logic in_stall;
    logic in_kind;
    logic [ID_W-1:0] in_task_id;
    logic [BURST_W-1:0] in_burst_ms;
    logic [TIME_W-1:0] in_time_ms;
    logic out_valid;
    logic out_stall;
    logic [EV_W-1:0] out_event;
    logic [ID_W-1:0] out_task_id;
    logic [PRIO_W-1:0] out_prio;
    logic [TIME_W-1:0] out_time_ms;
    logic out_last;

    int send_idle_pct;
    int rcv_idle_pct;
    int quiet_cycles;
    sched_scoreboard sb;

    tick_driven_mlfq_rr_fifo_scheduler DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_kind(in_kind),
        .i_task_id(in_task_id),
        .i_burst_ms(in_burst_ms),
        .i_time_ms(in_time_ms),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_event_res(out_event),
        .o_task_id_res(out_task_id),
        .o_priority_res(out_prio),
        .o_time_ms_res(out_time_ms),
        .o_last(out_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check each accepted event, then pick the next stall value.
    always @(posedge clk) begin
        t_result got;
        if (rst_n && out_valid && !out_stall) begin
            got.event_code = out_event;
            got.task_id = out_task_id;
            got.prio = out_prio;
            got.time_ms = out_time_ms;
            got.last = out_last;
            sb.check_event(got);
        end
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_CYCLES) begin
            $display("watchdog expired with %0d events outstanding", sb.due_events.size());
            $display("tick_driven_mlfq_rr_fifo_scheduler verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic kind, input logic [ID_W-1:0] id,
                             input logic [BURST_W-1:0] burst, input logic [TIME_W-1:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind <= kind;
        in_task_id <= id;
        in_burst_ms <= burst;
        in_time_ms <= stamp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.apply_input(kind, id, burst, stamp);
    endtask

    // Holds the sender off until every due event has been seen, plus a margin.
    task automatic wait_for_quiet(input int extra);
        in_valid <= 1'b0;
        while (sb.due_events.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_register(idx, value);
        @(posedge clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_stamp();
        int r;
        r = $urandom_range(19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // Bursts stay a few ticks long so that queues turn over; the longest only
    // when ticks are coarse enough to finish them.
    function automatic logic [BURST_W-1:0] pick_burst();
        int r;
        int top;
        r = $urandom_range(99);
        top = int'(sb.tick_len) * 8;
        if (r < 5) return 16'd1;
        if (r < 12 && sb.tick_len >= 10'd500) return 16'hFFFF;
        return BURST_W'($urandom_range(1, top));
    endfunction

    // Mostly a task that is neither queued nor running; sometimes any task.
    function automatic logic [ID_W-1:0] pick_task();
        logic [ID_W-1:0] id;
        id = ID_W'($urandom);
        if (sb.in_flight != '1 && $urandom_range(9) != 0)
            while (sb.in_flight[id]) id = id + 1'b1;
        return id;
    endfunction

    task automatic send_tick(input logic [TIME_W-1:0] stamp);
        send_item(1'b0, ID_W'($urandom), BURST_W'($urandom), stamp);
    endtask

    task automatic drain_queues(input int cap);
        int n = 0;
        while (!sb.cpu_idle() && n < cap) begin
            send_tick(pick_stamp());
            n++;
        end
    endtask

    task automatic run_phase(input logic [MODE_W-1:0] policy, input logic [SLICE_W-1:0] slice_ms,
                             input logic [TICKMS_W-1:0] tick_ms, input int ready_pct,
                             input bit drain);
        wait_for_quiet(SETTLE_CYCLES);
        write_reg(REG_MODE, 32'(policy));
        write_reg(REG_SLICE, 32'(slice_ms));
        write_reg(REG_TICK, 32'(tick_ms));
        repeat (PHASE_ITEMS) begin
            if ($urandom_range(99) < 2) wait_for_quiet(1);
            if ($urandom_range(99) < ready_pct)
                send_item(1'b1, pick_task(), pick_burst(), $urandom);
            else
                send_tick(pick_stamp());
        end
        if (drain) drain_queues(DRAIN_TICKS);
    endtask

    initial begin
        sb = new();
        send_idle_pct = 14;
        rcv_idle_pct = 68;
        quiet_cycles = 0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        in_kind <= 1'b0;
        in_task_id <= '0;
        in_burst_ms <= '0;
        in_time_ms <= '0;
        out_stall <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A tick with nothing to run, then every task readied once so that
        // every link entry gets written before any pop can read it.
        send_tick('0);
        for (int t = 0; t < SCHED_TASKS; t++)
            send_item(1'b1, ID_W'(t), (t == 0) ? 16'd1 : BURST_W'($urandom_range(1, 40)),
                      $urandom);
        // Readying a task that is still queued appends it a second time.
        send_item(1'b1, '0, 16'd1, '1);
        send_tick('1);
        drain_queues(DRAIN_TICKS);

        run_phase(MODE_MLFQ, 16'hFFFF, 10'd1000, 20, 1'b1);
        run_phase(MODE_RR, 16'd1, 10'd1, 25, 1'b0);

        send_idle_pct = 68;
        rcv_idle_pct = 14;
        run_phase(MODE_MLFQ, 16'd30, 10'd7, 25, 1'b0);
        run_phase(MODE_FIFO, 16'd100, 10'd20, 20, 1'b0);
        run_phase(MODE_UNUSED, 16'd40, 10'd15, 20, 1'b1);

        send_idle_pct = 0;
        rcv_idle_pct = 0;
        run_phase(MODE_MLFQ, 16'd1, 10'd1000, 20, 1'b1);
        run_phase(MODE_RR, 16'd25, 10'd10, 25, 1'b0);
        run_phase(MODE_MLFQ, 16'd20, 10'd5, 25, 1'b1);

        wait_for_quiet(2 * SETTLE_CYCLES);
        if (sb.errors == 0 && sb.due_events.size() == 0) begin
            $display("tick_driven_mlfq_rr_fifo_scheduler verification clean");
        end else begin
            $display("tick_driven_mlfq_rr_fifo_scheduler verification failed");
        end
        $finish;
    end
endmodule
